[src/keyframe_translation_sampler_unit_defines.svh]
// Assertion macros for the keyframe translation sampler.
// Used by modules that check their own control; expects clk and rst_n in scope.
`ifndef KEYFRAME_TRANSLATION_SAMPLER_UNIT_DEFINES_SVH
`define KEYFRAME_TRANSLATION_SAMPLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define KTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/kts_pkg.sv]
// Shared types, constants and arithmetic helpers of the keyframe translation sampler.
// No dependencies; used by every module of the block but kts_ram.
package kts_pkg;

  localparam int KEYS_PER_TRACK_DEF = 256;
  localparam int FRAME_W = 22;
  localparam int POS_W   = 32;
  localparam int TIME_W  = 31;
  localparam int DUR_W   = 27;
  localparam int MS_W    = 28;
  localparam int DIVD_W  = 64;
  localparam int NAXES   = 3;
  localparam int KEY_W   = FRAME_W + NAXES * POS_W;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    op_t                           op;
    logic                          track;
    logic [FRAME_W-1:0]            frame;
    logic [NAXES-1:0][POS_W-1:0]   v;
    logic [TIME_W-1:0]             time_ms;
  } item_t;

  typedef struct packed {
    logic [FRAME_W-1:0]            frame;
    logic [NAXES-1:0][POS_W-1:0]   v;
  } key_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [MS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quo;
    logic [MS_W-1:0]   rem;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_APP, S_MOD, S_MOD_WAIT, S_TRK, S_KEY0, S_RD, S_EV,
    S_PREP_NUM, S_PREP_DEN, S_AX, S_ABS, S_DGO, S_DWAIT, S_ACC,
    S_NEXT, S_SCALE, S_DONE
  } bk_state_t;

  // floor(f * 1000 / 30) = floor(f * 100 / 3); divide by 3 via reciprocal.
  function automatic logic [MS_W-1:0] ms_of(input logic [FRAME_W-1:0] f);
    logic [28:0] x;
    logic [60:0] p;
    x = {7'b0, f} * 29'd100;
    p = {32'b0, x} * 61'h0AAAAAAAB;
    return p[60:33];
  endfunction

  // Clamp to +-2^40, times 232, divide by 65536 toward zero, saturate to 32 bits.
  function automatic logic signed [POS_W-1:0] scale_out(input logic signed [63:0] s);
    logic signed [50:0] c;
    logic signed [50:0] r;
    logic signed [50:0] q;
    logic signed [POS_W-1:0] res;
    if (s > 64'sh100_0000_0000) begin
      c = 51'sh100_0000_0000;
    end else if (s < -64'sh100_0000_0000) begin
      c = -51'sh100_0000_0000;
    end else begin
      c = s[50:0];
    end
    r = (c <<< 8) - (c <<< 4) - (c <<< 3);
    q = r[50] ? ((r + 51'sd65535) >>> 16) : (r >>> 16);
    if (q > 51'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (q < -51'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = q[31:0];
    end
    return res;
  endfunction

endpackage

[src/kts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kts_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/kts_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on kts_pkg for widths and the request/response structs.
module kts_div (
  input  logic              clk,
  input  logic              rst_n,
  input  kts_pkg::div_req_t req,
  output kts_pkg::div_rsp_t rsp
);

  logic [kts_pkg::DIVD_W-1:0] q_r, q_nxt;
  logic [kts_pkg::MS_W:0]     r_r, r_nxt;
  logic [kts_pkg::MS_W-1:0]   d_r;
  logic [6:0]                 cnt_r;
  logic                       busy_r, done_r;
  logic [kts_pkg::MS_W:0]     r_sh;

  always_comb begin
    r_sh  = {r_r[kts_pkg::MS_W-1:0], q_r[kts_pkg::DIVD_W-1]};
    q_nxt = {q_r[kts_pkg::DIVD_W-2:0], 1'b0};
    r_nxt = r_sh;
    if (r_sh >= {1'b0, d_r}) begin
      r_nxt    = r_sh - {1'b0, d_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'(kts_pkg::DIVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      q_r <= req.dividend;
      r_r <= '0;
      d_r <= req.divisor;
    end else if (busy_r) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
  assign rsp.rem  = r_r[kts_pkg::MS_W-1:0];

endmodule

[src/kts_front.sv]
// Front end: accepts input items, decodes the command and queues them.
// Depends on kts_pkg for the queued item type.
module kts_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_cmd,
  input  logic                       in_track,
  input  logic [kts_pkg::FRAME_W-1:0] in_key_frame,
  input  logic signed [31:0]         in_key_x,
  input  logic signed [31:0]         in_key_y,
  input  logic signed [31:0]         in_key_z,
  input  logic [kts_pkg::TIME_W-1:0] in_time_ms,
  output logic                       q_valid,
  input  logic                       q_ready,
  output kts_pkg::item_t             q_item
);

  kts_pkg::item_t q_r [2];
  kts_pkg::item_t item_c;
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           push, pop;

  always_comb begin
    case (in_cmd)
      kts_pkg::OP_CLEAR:  item_c.op = kts_pkg::OP_CLEAR;
      kts_pkg::OP_APPEND: item_c.op = kts_pkg::OP_APPEND;
      kts_pkg::OP_SAMPLE: item_c.op = kts_pkg::OP_SAMPLE;
      default:            item_c.op = kts_pkg::OP_NOP;
    endcase
    item_c.track   = in_track;
    item_c.frame   = in_key_frame;
    item_c.v       = {in_key_z, in_key_y, in_key_x};
    item_c.time_ms = in_time_ms;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item_c;
    end
  end

endmodule

[src/kts_back.sv]
// Back end: key store, bracket search, interpolation and output register.
// Depends on kts_pkg, kts_ram, kts_div and the assertion macro header.
`include "keyframe_translation_sampler_unit_defines.svh"

module kts_back #(
  parameter int KEYS_PER_TRACK = kts_pkg::KEYS_PER_TRACK_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [kts_pkg::DUR_W-1:0]  clip_ms,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  kts_pkg::item_t             q_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_status,
  output logic signed [31:0]         out_pos_x,
  output logic signed [31:0]         out_pos_y,
  output logic signed [31:0]         out_pos_z
);

  localparam int IW    = $clog2(KEYS_PER_TRACK);
  localparam int CW    = $clog2(KEYS_PER_TRACK + 1);
  localparam int DEPTH = 2 * (1 << IW);
  localparam int AW    = IW + 1;

  kts_pkg::bk_state_t st_r, st_nxt;
  kts_pkg::item_t     item_r;
  kts_pkg::key_t      a_r, b_r, rkey;
  kts_pkg::div_req_t  dreq;
  kts_pkg::div_rsp_t  drsp;

  logic [CW-1:0]               center_cnt_r, groove_cnt_r, app_cnt, trk_cnt;
  logic [CW-1:0]               j_r;
  logic                        trk_r, hasb_r;
  logic [1:0]                  ax_r;
  logic [kts_pkg::TIME_W-1:0]  t_r;
  logic signed [31:0]          num_r;
  logic [kts_pkg::MS_W-1:0]    den_r;
  logic signed [64:0]          prod_r, prod_neg;
  logic                        neg_r;
  logic [63:0]                 mag_r;
  logic signed [63:0]          qs_r;
  logic signed [63:0]          acc_r [kts_pkg::NAXES];
  logic                        res_status_r;
  logic signed [31:0]          res_pos_r [kts_pkg::NAXES];
  logic                        out_valid_r;
  logic                        out_status_r;
  logic signed [31:0]          out_pos_r [kts_pkg::NAXES];

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [kts_pkg::KEY_W-1:0]   ram_wdata, ram_rdata;
  logic [kts_pkg::FRAME_W-1:0] ms_in;
  logic [kts_pkg::MS_W-1:0]    ms_c;
  logic                        app_full, interp, ax_last, out_free;
  logic signed [32:0]          diff_c;
  logic signed [63:0]          av64;

  kts_ram #(.W(kts_pkg::KEY_W), .D(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign rkey     = kts_pkg::key_t'(ram_rdata);
  assign app_cnt  = item_r.track ? groove_cnt_r : center_cnt_r;
  assign trk_cnt  = trk_r ? groove_cnt_r : center_cnt_r;
  assign app_full = (app_cnt >= CW'(KEYS_PER_TRACK));
  assign interp   = hasb_r && (b_r.frame > a_r.frame);
  assign ax_last  = (ax_r == 2'(kts_pkg::NAXES - 1));
  assign out_free = !out_valid_r || out_ready;
  assign diff_c   = {b_r.v[ax_r][31], b_r.v[ax_r]} - {a_r.v[ax_r][31], a_r.v[ax_r]};
  assign av64     = {{32{a_r.v[ax_r][31]}}, a_r.v[ax_r]};
  assign prod_neg = -prod_r;
  assign ms_c     = kts_pkg::ms_of(ms_in);

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      kts_pkg::S_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            kts_pkg::OP_APPEND: st_nxt = kts_pkg::S_APP;
            kts_pkg::OP_SAMPLE: st_nxt = kts_pkg::S_MOD;
            default:            st_nxt = kts_pkg::S_DONE;
          endcase
        end
      end
      kts_pkg::S_APP:      st_nxt = kts_pkg::S_DONE;
      kts_pkg::S_MOD:      st_nxt = (clip_ms != '0) ? kts_pkg::S_MOD_WAIT : kts_pkg::S_TRK;
      kts_pkg::S_MOD_WAIT: if (drsp.done) st_nxt = kts_pkg::S_TRK;
      kts_pkg::S_TRK:      st_nxt = (trk_cnt == '0) ? kts_pkg::S_NEXT : kts_pkg::S_KEY0;
      kts_pkg::S_KEY0:     st_nxt = kts_pkg::S_RD;
      kts_pkg::S_RD:       st_nxt = (j_r >= trk_cnt) ? kts_pkg::S_PREP_NUM : kts_pkg::S_EV;
      kts_pkg::S_EV: begin
        st_nxt = (t_r < {3'b0, ms_c}) ? kts_pkg::S_PREP_NUM : kts_pkg::S_RD;
      end
      kts_pkg::S_PREP_NUM: st_nxt = kts_pkg::S_PREP_DEN;
      kts_pkg::S_PREP_DEN: st_nxt = kts_pkg::S_AX;
      kts_pkg::S_AX: begin
        if (interp) begin
          st_nxt = kts_pkg::S_ABS;
        end else if (ax_last) begin
          st_nxt = kts_pkg::S_NEXT;
        end
      end
      kts_pkg::S_ABS:      st_nxt = kts_pkg::S_DGO;
      kts_pkg::S_DGO:      st_nxt = kts_pkg::S_DWAIT;
      kts_pkg::S_DWAIT:    if (drsp.done) st_nxt = kts_pkg::S_ACC;
      kts_pkg::S_ACC:      st_nxt = ax_last ? kts_pkg::S_NEXT : kts_pkg::S_AX;
      kts_pkg::S_NEXT:     st_nxt = trk_r ? kts_pkg::S_SCALE : kts_pkg::S_TRK;
      kts_pkg::S_SCALE:    st_nxt = kts_pkg::S_DONE;
      kts_pkg::S_DONE:     if (out_free) st_nxt = kts_pkg::S_IDLE;
      default:             st_nxt = kts_pkg::S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_ready   = (st_r == kts_pkg::S_IDLE);
    ram_we    = (st_r == kts_pkg::S_APP) && !app_full;
    ram_waddr = {item_r.track, app_cnt[IW-1:0]};
    ram_wdata = {item_r.frame, item_r.v};
    ram_raddr = {trk_r, j_r[IW-1:0]};
    case (st_r)
      kts_pkg::S_EV:       ms_in = rkey.frame;
      kts_pkg::S_PREP_DEN: ms_in = b_r.frame - a_r.frame;
      default:             ms_in = a_r.frame;
    endcase
    dreq.start    = 1'b0;
    dreq.dividend = mag_r;
    dreq.divisor  = den_r;
    case (st_r)
      kts_pkg::S_MOD: begin
        dreq.start    = (clip_ms != '0);
        dreq.dividend = {33'b0, item_r.time_ms};
        dreq.divisor  = {1'b0, clip_ms};
      end
      kts_pkg::S_DGO: dreq.start = 1'b1;
      default:        dreq.start = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= kts_pkg::S_IDLE;
      center_cnt_r <= '0;
      groove_cnt_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == kts_pkg::S_IDLE && q_valid && q_item.op == kts_pkg::OP_CLEAR) begin
        center_cnt_r <= '0;
        groove_cnt_r <= '0;
      end
      if (ram_we) begin
        if (item_r.track) groove_cnt_r <= groove_cnt_r + CW'(1);
        else              center_cnt_r <= center_cnt_r + CW'(1);
      end
      if (st_r == kts_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (st_r)
      kts_pkg::S_IDLE: begin
        item_r       <= q_item;
        res_status_r <= 1'b0;
        trk_r        <= 1'b0;
        j_r          <= '0;
        for (int i = 0; i < kts_pkg::NAXES; i++) begin
          acc_r[i]     <= '0;
          res_pos_r[i] <= '0;
        end
      end
      kts_pkg::S_APP:      res_status_r <= app_full;
      kts_pkg::S_MOD:      t_r <= item_r.time_ms;
      kts_pkg::S_MOD_WAIT: if (drsp.done) t_r <= {4'b0, drsp.rem[kts_pkg::DUR_W-1:0]};
      kts_pkg::S_KEY0: begin
        a_r    <= rkey;
        hasb_r <= 1'b0;
        j_r    <= CW'(1);
      end
      kts_pkg::S_EV: begin
        if (t_r < {3'b0, ms_c}) begin
          b_r    <= rkey;
          hasb_r <= 1'b1;
        end else begin
          a_r <= rkey;
          j_r <= j_r + CW'(1);
        end
      end
      kts_pkg::S_PREP_NUM: begin
        num_r <= $signed({1'b0, t_r}) - $signed({4'b0, ms_c});
        ax_r  <= 2'd0;
      end
      kts_pkg::S_PREP_DEN: den_r <= ms_c;
      kts_pkg::S_AX: begin
        if (interp) begin
          prod_r <= diff_c * num_r;
        end else begin
          acc_r[ax_r] <= acc_r[ax_r] + av64;
          ax_r        <= ax_r + 2'd1;
        end
      end
      kts_pkg::S_ABS: begin
        neg_r <= prod_r[64];
        mag_r <= prod_r[64] ? prod_neg[63:0] : prod_r[63:0];
      end
      kts_pkg::S_DWAIT: if (drsp.done) qs_r <= neg_r ? -$signed(drsp.quo) : $signed(drsp.quo);
      kts_pkg::S_ACC: begin
        acc_r[ax_r] <= acc_r[ax_r] + av64 + qs_r;
        ax_r        <= ax_r + 2'd1;
      end
      kts_pkg::S_NEXT: begin
        trk_r <= 1'b1;
        j_r   <= '0;
      end
      kts_pkg::S_SCALE: begin
        for (int i = 0; i < kts_pkg::NAXES; i++) begin
          res_pos_r[i] <= kts_pkg::scale_out(acc_r[i]);
        end
      end
      default: ;
    endcase
    if (st_r == kts_pkg::S_DONE && out_free) begin
      out_status_r <= res_status_r;
      for (int i = 0; i < kts_pkg::NAXES; i++) begin
        out_pos_r[i] <= res_pos_r[i];
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_pos_x  = out_pos_r[0];
  assign out_pos_y  = out_pos_r[1];
  assign out_pos_z  = out_pos_r[2];

  `KTS_ASSERT_NOW(a_div_idle_on_start, dreq.start, !drsp.busy, "divider started while busy")
  `KTS_ASSERT_NOW(a_cnt_bound, 1'b1, (center_cnt_r <= CW'(KEYS_PER_TRACK)) && (groove_cnt_r <= CW'(KEYS_PER_TRACK)), "key count past track size")
  `KTS_ASSERT_NEXT(a_done_loads_out, (st_r == kts_pkg::S_DONE) && out_free, out_valid_r && (st_r == kts_pkg::S_IDLE), "result not handed to output register")
  `KTS_ASSERT_NOW(a_ev_after_rd, st_r == kts_pkg::S_EV, $past(st_r) == kts_pkg::S_RD, "key evaluated without a read")

endmodule

[src/keyframe_translation_sampler_unit.sv]
// Top level of the keyframe translation sampler: clip length register,
// front queue and back end. Depends on kts_pkg, kts_front and kts_back.
//
// Channels: in_valid/in_ready carries one command per item (clear all keys,
//   append a key to the center or groove track, sample a position);
//   out_valid/out_ready returns exactly one result item per input item.
//   cfg_we/cfg_wdata write the clip length; write it only while idle.
// Sample steps: when the clip length is nonzero the back end first divides
//   the time by it for the remainder. It then searches each non-empty track
//   for the bracket of that time on the single key store read port, and
//   when the bracket is a true pair it divides once per axis to interpolate;
//   the shared one-bit-per-cycle divider serves both. Clear, append and
//   unused codes skip these steps.
// Throughput: one item at a time in the back end; the two-entry queue takes
//   new items meanwhile and the output register holds a finished result.
// Reset: clears both key counts, the clip length and all handshake state; the
//   key store keeps its contents and is never read before it is written.
// Stall: while out_ready is low the result holds, the back end waits with its
//   next result and the queue fills, after which in_ready drops.
module keyframe_translation_sampler_unit #(
  parameter int KEYS_PER_TRACK = kts_pkg::KEYS_PER_TRACK_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [kts_pkg::DUR_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_cmd,
  input  logic                       in_track,
  input  logic [kts_pkg::FRAME_W-1:0] in_key_frame,
  input  logic signed [31:0]         in_key_x,
  input  logic signed [31:0]         in_key_y,
  input  logic signed [31:0]         in_key_z,
  input  logic [kts_pkg::TIME_W-1:0] in_time_ms,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_status,
  output logic signed [31:0]         out_pos_x,
  output logic signed [31:0]         out_pos_y,
  output logic signed [31:0]         out_pos_z
);

  logic [kts_pkg::DUR_W-1:0] duration_r;
  logic                      q_valid, q_ready;
  kts_pkg::item_t            q_item;

  // Clip length register; zero turns time wrapping off.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_r <= '0;
    end else if (cfg_we) begin
      duration_r <= cfg_wdata;
    end
  end

  // Front: accept, decode and queue items.
  kts_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_track     (in_track),
    .in_key_frame (in_key_frame),
    .in_key_x     (in_key_x),
    .in_key_y     (in_key_y),
    .in_key_z     (in_key_z),
    .in_time_ms   (in_time_ms),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item)
  );

  // Back: key store, search, interpolation, output register.
  kts_back #(.KEYS_PER_TRACK(KEYS_PER_TRACK)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .clip_ms     (duration_r),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_pos_x   (out_pos_x),
    .out_pos_y   (out_pos_y),
    .out_pos_z   (out_pos_z)
  );

endmodule
